// ----- src/positional_audio_bearing_and_attenuation_unit_assert.svh -----
// assertion macros for the positional audio bearing and attenuation unit
`ifndef POSITIONAL_AUDIO_BEARING_AND_ATTENUATION_UNIT_ASSERT_SVH
`define POSITIONAL_AUDIO_BEARING_AND_ATTENUATION_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
`define PABAU_ASSERT_HOLD(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) cond) else $error("assertion failed");
`define PABAU_ASSERT_NEXT(lbl, clk, a, b) \
  lbl: assert property (@(posedge clk) a |=> b) else $error("assertion failed");
`else
`define PABAU_ASSERT_HOLD(lbl, clk, rst, cond)
`define PABAU_ASSERT_NEXT(lbl, clk, a, b)
`endif
`endif

// ----- src/pabau_pkg.sv -----
// shared types and constants of the bearing and attenuation unit
package pabau_pkg;

  localparam int ANG_W = 28;
  localparam int CORDIC_STEPS = 17;
  localparam int LEVEL_STEPS = 8;
  localparam int CORDIC_SHIFT = 24;
  localparam int DEG_SHIFT = 16;
  localparam int FACING_Z_RESET = 256;
  localparam int MAX_DEG = 359;
  localparam int LEVEL_SCALE = 65025;

  typedef logic signed [ANG_W-1:0] ang_t;

  localparam ang_t ANG_FULL = ang_t'(360 * 65536);
  localparam ang_t ANG_HALF = ang_t'(180 * 65536);
  localparam ang_t ANG_QUARTER = ang_t'(90 * 65536);

  localparam logic [2:0] REG_LISTENER_X = 3'd0;
  localparam logic [2:0] REG_LISTENER_Y = 3'd1;
  localparam logic [2:0] REG_LISTENER_Z = 3'd2;
  localparam logic [2:0] REG_FACING_X = 3'd3;
  localparam logic [2:0] REG_FACING_Z = 3'd4;

  typedef struct packed {
    logic       valid;
    logic [3:0] chan;
    logic       snd_fix;
    logic       fac_fix;
    logic       lvl_sat;
    logic       lvl_zero;
  } ctrl_t;

  function automatic ang_t step_angle(input int idx);
    case (idx)
      0: step_angle = ang_t'(2949120);
      1: step_angle = ang_t'(1740967);
      2: step_angle = ang_t'(919879);
      3: step_angle = ang_t'(466945);
      4: step_angle = ang_t'(234379);
      5: step_angle = ang_t'(117304);
      6: step_angle = ang_t'(58666);
      7: step_angle = ang_t'(29335);
      8: step_angle = ang_t'(14668);
      9: step_angle = ang_t'(7334);
      10: step_angle = ang_t'(3667);
      11: step_angle = ang_t'(1833);
      12: step_angle = ang_t'(917);
      13: step_angle = ang_t'(458);
      14: step_angle = ang_t'(229);
      15: step_angle = ang_t'(115);
      16: step_angle = ang_t'(57);
      default: step_angle = ang_t'(0);
    endcase
  endfunction

endpackage

// ----- src/pabau_if.sv -----
// input and output channel interfaces
interface pabau_in_if #(parameter int POSITION_WIDTH = 24);
  logic                             valid;
  logic                             ready;
  logic signed [4:0]                mix_channel;
  logic signed [POSITION_WIDTH-1:0] sound_x;
  logic signed [POSITION_WIDTH-1:0] sound_y;
  logic signed [POSITION_WIDTH-1:0] sound_z;
  modport source (output valid, mix_channel, sound_x, sound_y, sound_z, input ready);
  modport sink (input valid, mix_channel, sound_x, sound_y, sound_z, output ready);
endinterface

interface pabau_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] out_channel;
  logic [8:0] bearing_degrees;
  logic [7:0] distance_level;
  modport source (output valid, out_channel, bearing_degrees, distance_level, input ready);
  modport sink (input valid, out_channel, bearing_degrees, distance_level, output ready);
endinterface

// ----- src/pabau_front.sv -----
// offset, squares, cordic setup and scaled distance stages
module pabau_front #(
  parameter int PW = 24,
  parameter int FB = 8,
  parameter int W = 51,
  parameter int SMW = 14,
  parameter int LW = 46
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic signed [4:0]     ch,
  input  logic signed [PW-1:0]  sx,
  input  logic signed [PW-1:0]  sy,
  input  logic signed [PW-1:0]  sz,
  input  logic signed [PW-1:0]  lx,
  input  logic signed [PW-1:0]  ly,
  input  logic signed [PW-1:0]  lz,
  input  logic signed [PW-1:0]  fx,
  input  logic signed [PW-1:0]  fz,
  output pabau_pkg::ctrl_t      ctrl_out,
  input  logic                  out_ready,
  output logic signed [W-1:0]   sa,
  output logic signed [W-1:0]   sb,
  output pabau_pkg::ang_t       sang,
  output logic signed [W-1:0]   fa,
  output logic signed [W-1:0]   fb,
  output pabau_pkg::ang_t       fang,
  output logic [LW-1:0]         lhs
);
  localparam int CW = (PW + 1 > SMW) ? PW + 1 : SMW;
  localparam logic [CW-1:0] LIM = CW'(1) << (5 + FB);
  localparam int SW = 2 * SMW + 2;

  logic                 v1;
  logic [3:0]           ch1;
  logic signed [PW:0]   dx, dy, dz, fx1, fz1;
  logic                 r1, r2, r3;

  pabau_pkg::ctrl_t     c2, c2_next;
  logic [2*SMW-1:0]     qx, qy, qz;
  logic signed [W-1:0]  sa2, sb2, fa2, fb2;
  pabau_pkg::ang_t      sang2, fang2;

  logic [PW:0]          mx, my, mz;
  logic [SMW-1:0]       tx, ty, tz;
  logic signed [W-1:0]  sa_next, sb_next, fa_next, fb_next;
  pabau_pkg::ang_t      sang_next, fang_next;
  logic                 sfix, ffix;
  logic [SW-1:0]        sum;
  pabau_pkg::ctrl_t     ctrl_next;

  assign r3 = !ctrl_out.valid || out_ready;
  assign r2 = !c2.valid || r3;
  assign r1 = !v1 || r2;
  assign in_ready = r1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (r1) begin
      v1 <= in_valid && !ch[4];
    end
  end

  always_ff @(posedge clk) begin
    if (r1) begin
      ch1 <= ch[3:0];
      dx <= (PW+1)'(sx) - (PW+1)'(lx);
      dy <= (PW+1)'(sy) - (PW+1)'(ly);
      dz <= (PW+1)'(sz) - (PW+1)'(lz);
      fx1 <= (PW+1)'(fx);
      fz1 <= (PW+1)'(fz);
    end
  end

  function automatic logic [PW:0] magn(input logic signed [PW:0] d);
    magn = d[PW] ? (PW+1)'(-d) : (PW+1)'(d);
  endfunction

  always_comb begin
    logic signed [W-1:0] a0, b0;
    mx = magn(dx);
    my = magn(dy);
    mz = magn(dz);
    tx = SMW'(mx);
    ty = SMW'(my);
    tz = SMW'(mz);
    sfix = (dx == '0) || (dz == '0);
    ffix = (fx1 == '0) || (fz1 == '0);
    a0 = W'(dz) <<< pabau_pkg::CORDIC_SHIFT;
    b0 = W'(dx) <<< pabau_pkg::CORDIC_SHIFT;
    if (dz < 0) begin
      sa_next = -a0;
      sb_next = -b0;
      sang_next = pabau_pkg::ANG_HALF;
    end else begin
      sa_next = a0;
      sb_next = b0;
      sang_next = '0;
    end
    if (dx == '0) begin
      sang_next = (dz < 0) ? pabau_pkg::ANG_HALF : pabau_pkg::ang_t'(0);
    end else if (dz == '0) begin
      sang_next = (dx > 0) ? pabau_pkg::ANG_QUARTER : -pabau_pkg::ANG_QUARTER;
    end
    a0 = W'(fz1) <<< pabau_pkg::CORDIC_SHIFT;
    b0 = W'(fx1) <<< pabau_pkg::CORDIC_SHIFT;
    if (fz1 < 0) begin
      fa_next = -a0;
      fb_next = -b0;
      fang_next = pabau_pkg::ANG_HALF;
    end else begin
      fa_next = a0;
      fb_next = b0;
      fang_next = '0;
    end
    if (fx1 == '0) begin
      fang_next = (fz1 < 0) ? pabau_pkg::ANG_HALF : pabau_pkg::ang_t'(0);
    end else if (fz1 == '0) begin
      fang_next = (fx1 > 0) ? pabau_pkg::ANG_QUARTER : -pabau_pkg::ANG_QUARTER;
    end
    c2_next.valid = v1;
    c2_next.chan = ch1;
    c2_next.snd_fix = sfix;
    c2_next.fac_fix = ffix;
    c2_next.lvl_sat = (CW'(mx) > LIM) || (CW'(my) > LIM) || (CW'(mz) > LIM);
    c2_next.lvl_zero = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c2.valid <= 1'b0;
    end else if (r2) begin
      c2 <= c2_next;
    end
  end

  always_ff @(posedge clk) begin
    if (r2) begin
      qx <= (2*SMW)'(tx) * (2*SMW)'(tx);
      qy <= (2*SMW)'(ty) * (2*SMW)'(ty);
      qz <= (2*SMW)'(tz) * (2*SMW)'(tz);
      sa2 <= sa_next;
      sb2 <= sb_next;
      sang2 <= sang_next;
      fa2 <= fa_next;
      fb2 <= fb_next;
      fang2 <= fang_next;
    end
  end

  assign sum = SW'(qx) + SW'(qy) + SW'(qz);

  always_comb begin
    ctrl_next = c2;
    ctrl_next.lvl_zero = sum <= (SW'(1) << (2 * FB));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl_out.valid <= 1'b0;
    end else if (r3) begin
      ctrl_out <= ctrl_next;
    end
  end

  always_ff @(posedge clk) begin
    if (r3) begin
      lhs <= LW'(sum) * LW'(pabau_pkg::LEVEL_SCALE);
      sa <= sa2;
      sb <= sb2;
      sang <= sang2;
      fa <= fa2;
      fb <= fb2;
      fang <= fang2;
    end
  end
endmodule

// ----- src/pabau_cell.sv -----
// one cordic rotation step for both vectors and, below LEVEL_STEPS, one level search bit
module pabau_cell #(
  parameter int W = 51,
  parameter int LW = 46,
  parameter int FB = 8,
  parameter int IDX = 0
) (
  input  logic                clk,
  input  logic                rst,
  input  pabau_pkg::ctrl_t    ctrl_in,
  output logic                in_ready,
  input  logic signed [W-1:0] sa_in,
  input  logic signed [W-1:0] sb_in,
  input  pabau_pkg::ang_t     sang_in,
  input  logic signed [W-1:0] fa_in,
  input  logic signed [W-1:0] fb_in,
  input  pabau_pkg::ang_t     fang_in,
  input  logic [LW-1:0]       lhs_in,
  input  logic [7:0]          lvl_in,
  output pabau_pkg::ctrl_t    ctrl_out,
  input  logic                out_ready,
  output logic signed [W-1:0] sa_out,
  output logic signed [W-1:0] sb_out,
  output pabau_pkg::ang_t     sang_out,
  output logic signed [W-1:0] fa_out,
  output logic signed [W-1:0] fb_out,
  output pabau_pkg::ang_t     fang_out,
  output logic [LW-1:0]       lhs_out,
  output logic [7:0]          lvl_out
);
  localparam pabau_pkg::ang_t STEP = pabau_pkg::step_angle(IDX);

  logic signed [W-1:0] sa_next, sb_next, fa_next, fb_next;
  pabau_pkg::ang_t     sang_next, fang_next;
  logic [7:0]          lvl_next;

  assign in_ready = !ctrl_out.valid || out_ready;

  always_comb begin
    if (sb_in > 0) begin
      sa_next = sa_in + (sb_in >>> IDX);
      sb_next = sb_in - (sa_in >>> IDX);
      sang_next = ctrl_in.snd_fix ? sang_in : sang_in + STEP;
    end else begin
      sa_next = sa_in - (sb_in >>> IDX);
      sb_next = sb_in + (sa_in >>> IDX);
      sang_next = ctrl_in.snd_fix ? sang_in : sang_in - STEP;
    end
    if (fb_in > 0) begin
      fa_next = fa_in + (fb_in >>> IDX);
      fb_next = fb_in - (fa_in >>> IDX);
      fang_next = ctrl_in.fac_fix ? fang_in : fang_in + STEP;
    end else begin
      fa_next = fa_in - (fb_in >>> IDX);
      fb_next = fb_in + (fa_in >>> IDX);
      fang_next = ctrl_in.fac_fix ? fang_in : fang_in - STEP;
    end
  end

  generate
    if (IDX < pabau_pkg::LEVEL_STEPS) begin : g_level
      logic [7:0]  cand;
      logic [12:0] t;
      logic [25:0] tt;
      always_comb begin
        cand = lvl_in | (8'd1 << (pabau_pkg::LEVEL_STEPS - 1 - IDX));
        t = 13'd255 + 13'd31 * 13'(cand);
        tt = 26'(t) * 26'(t);
        lvl_next = (lhs_in >= (LW'(tt) << (2 * FB))) ? cand : lvl_in;
      end
    end else begin : g_pass
      assign lvl_next = lvl_in;
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl_out.valid <= 1'b0;
    end else if (in_ready) begin
      ctrl_out <= ctrl_in;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      sa_out <= sa_next;
      sb_out <= sb_next;
      sang_out <= sang_next;
      fa_out <= fa_next;
      fb_out <= fb_next;
      fang_out <= fang_next;
      lhs_out <= lhs_in;
      lvl_out <= lvl_next;
    end
  end
endmodule

// ----- src/positional_audio_bearing_and_attenuation_unit.sv -----
// top level: config registers, front stages, cordic cell row, bearing wrap, output register
// 21 pipeline stages, the first loaded at the input transfer
// throughput: one item per cycle while the output is not stalled; every stage holds one item and the row advances
// whenever the next stage is free, so a stalled output only fills the bubbles
// reset: synchronous, clears all stage valids and loads listener 0,0,0 facing +z
`include "positional_audio_bearing_and_attenuation_unit_assert.svh"
module positional_audio_bearing_and_attenuation_unit #(
  parameter int POSITION_WIDTH = 24,
  parameter int FRACTION_BITS = 8
) (
  input  logic                      clk,
  input  logic                      rst,
  pabau_in_if.sink                  in_ch,
  pabau_out_if.source               out_ch,
  input  logic                      cfg_we,
  input  logic [2:0]                cfg_index,
  input  logic [POSITION_WIDTH-1:0] cfg_data
);
  localparam int PW = POSITION_WIDTH;
  localparam int W = PW + 1 + pabau_pkg::CORDIC_SHIFT + 2;
  localparam int SMW = 6 + FRACTION_BITS;
  localparam int LW = 2 * SMW + 2 + 16;
  localparam int N = pabau_pkg::CORDIC_STEPS;

  logic signed [PW-1:0] listener_x, listener_y, listener_z, facing_x, facing_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      listener_x <= '0;
      listener_y <= '0;
      listener_z <= '0;
      facing_x <= '0;
      facing_z <= PW'(pabau_pkg::FACING_Z_RESET);
    end else if (cfg_we) begin
      case (cfg_index)
        pabau_pkg::REG_LISTENER_X: listener_x <= cfg_data;
        pabau_pkg::REG_LISTENER_Y: listener_y <= cfg_data;
        pabau_pkg::REG_LISTENER_Z: listener_z <= cfg_data;
        pabau_pkg::REG_FACING_X: facing_x <= cfg_data;
        pabau_pkg::REG_FACING_Z: facing_z <= cfg_data;
        default: ;
      endcase
    end
  end

  pabau_pkg::ctrl_t    ctrl [0:N];
  logic                rdy [0:N];
  logic signed [W-1:0] sa [0:N];
  logic signed [W-1:0] sb [0:N];
  logic signed [W-1:0] fa [0:N];
  logic signed [W-1:0] fb [0:N];
  pabau_pkg::ang_t     sang [0:N];
  pabau_pkg::ang_t     fang [0:N];
  logic [LW-1:0]       lhs [0:N];
  logic [7:0]          lvl [0:N];

  assign lvl[0] = '0;

  pabau_front #(.PW(PW), .FB(FRACTION_BITS), .W(W), .SMW(SMW), .LW(LW)) u_front (
    .clk(clk), .rst(rst),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .ch(in_ch.mix_channel), .sx(in_ch.sound_x), .sy(in_ch.sound_y), .sz(in_ch.sound_z),
    .lx(listener_x), .ly(listener_y), .lz(listener_z), .fx(facing_x), .fz(facing_z),
    .ctrl_out(ctrl[0]), .out_ready(rdy[0]),
    .sa(sa[0]), .sb(sb[0]), .sang(sang[0]), .fa(fa[0]), .fb(fb[0]), .fang(fang[0]),
    .lhs(lhs[0])
  );

  for (genvar i = 0; i < N; i++) begin : g_cell
    pabau_cell #(.W(W), .LW(LW), .FB(FRACTION_BITS), .IDX(i)) u_cell (
      .clk(clk), .rst(rst),
      .ctrl_in(ctrl[i]), .in_ready(rdy[i]),
      .sa_in(sa[i]), .sb_in(sb[i]), .sang_in(sang[i]),
      .fa_in(fa[i]), .fb_in(fb[i]), .fang_in(fang[i]),
      .lhs_in(lhs[i]), .lvl_in(lvl[i]),
      .ctrl_out(ctrl[i+1]), .out_ready(rdy[i+1]),
      .sa_out(sa[i+1]), .sb_out(sb[i+1]), .sang_out(sang[i+1]),
      .fa_out(fa[i+1]), .fb_out(fb[i+1]), .fang_out(fang[i+1]),
      .lhs_out(lhs[i+1]), .lvl_out(lvl[i+1])
    );
  end

  pabau_pkg::ang_t rel0, rel1, rel2, rel3;
  logic [pabau_pkg::ANG_W-pabau_pkg::DEG_SHIFT-1:0] deg;
  logic [8:0] deg_next;
  logic [7:0] level_next;

  always_comb begin
    rel0 = sang[N] - fang[N];
    rel1 = (rel0 < 0) ? rel0 + pabau_pkg::ANG_FULL : rel0;
    rel2 = (rel1 < 0) ? rel1 + pabau_pkg::ANG_FULL : rel1;
    rel3 = (rel2 >= pabau_pkg::ANG_FULL) ? rel2 - pabau_pkg::ANG_FULL : rel2;
    deg = rel3[pabau_pkg::ANG_W-1:pabau_pkg::DEG_SHIFT];
    if (deg > (pabau_pkg::ANG_W-pabau_pkg::DEG_SHIFT)'(pabau_pkg::MAX_DEG)) begin
      deg_next = 9'(pabau_pkg::MAX_DEG);
    end else begin
      deg_next = deg[8:0];
    end
    if (ctrl[N].lvl_sat) begin
      level_next = 8'd255;
    end else if (ctrl[N].lvl_zero) begin
      level_next = 8'd0;
    end else begin
      level_next = lvl[N];
    end
  end

  assign rdy[N] = !out_ch.valid || out_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (rdy[N]) begin
      out_ch.valid <= ctrl[N].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[N]) begin
      out_ch.out_channel <= ctrl[N].chan;
      out_ch.bearing_degrees <= deg_next;
      out_ch.distance_level <= level_next;
    end
  end

  `PABAU_ASSERT_HOLD(a_bearing_range, clk, rst, out_ch.valid |-> out_ch.bearing_degrees <= 9'd359)
  `PABAU_ASSERT_NEXT(a_reset_clears_out, clk, rst, !out_ch.valid)
  `PABAU_ASSERT_HOLD(a_sat_level, clk, rst, (rdy[N] && ctrl[N].valid && ctrl[N].lvl_sat) |=> out_ch.distance_level == 8'd255)

endmodule

// ----- tb/positional_audio_bearing_and_attenuation_unit_tb.sv -----
// self-checking testbench for the positional audio bearing and attenuation unit
module positional_audio_bearing_and_attenuation_unit_tb;

  localparam int PW = 24;
  localparam int FB = 8;
  localparam int DRAIN_CYCLES = 30;
  localparam int CYCLE_LIMIT = 400000;
  localparam logic [2:0] REG_SPARE = 3'd7;
  localparam logic [2:0] REG_GAP = 3'd5;
  localparam longint DEG = 65536;
  localparam longint ARC_Q16 [17] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115, 57
  };

  typedef struct {
    logic [3:0] chan;
    logic [8:0] bearing;
    logic [7:0] level;
  } placement_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [PW-1:0] cfg_data = '0;

  pabau_in_if #(.POSITION_WIDTH(PW)) in_ch ();
  pabau_out_if out_ch ();

  positional_audio_bearing_and_attenuation_unit #(
    .POSITION_WIDTH(PW),
    .FRACTION_BITS(FB)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .in_ch(in_ch.sink),
    .out_ch(out_ch.source),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  logic signed [PW-1:0] lis_x, lis_y, lis_z, face_x, face_z;
  placement_t placement_q[$];
  int mismatches = 0;
  int send_idle = 0;
  int recv_stall = 0;
  int hold_off = 0;
  longint cycles = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.mix_channel = '0;
    in_ch.sound_x = '0;
    in_ch.sound_y = '0;
    in_ch.sound_z = '0;
    out_ch.ready = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("** positional_audio_bearing_and_attenuation_unit: FAILED **");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_stall);
    end
  end

  // heading from +z toward +x in Q.16 degrees
  function automatic longint heading_q16(longint x, longint z);
    longint a, b, ang, da, db;
    ang = 0;
    if (x == 0 && z == 0) return 0;
    if (x == 0) return (z > 0) ? 0 : 180 * DEG;
    if (z == 0) return (x > 0) ? 90 * DEG : -90 * DEG;
    a = z * (64'sd1 <<< 24);
    b = x * (64'sd1 <<< 24);
    if (a < 0) begin
      a = -a;
      b = -b;
      ang = 180 * DEG;
    end
    for (int i = 0; i < 17; i++) begin
      da = b >>> i;
      db = a >>> i;
      if (b > 0) begin
        a = a + da;
        b = b - db;
        ang = ang + ARC_Q16[i];
      end else begin
        a = a - da;
        b = b + db;
        ang = ang - ARC_Q16[i];
      end
    end
    return ang;
  endfunction

  function automatic logic [7:0] level_of(longint dx, longint dy, longint dz);
    longint unit, lim, s, lhs, t;
    int lo, hi, mid;
    unit = 64'sd1 <<< FB;
    lim = 32 * unit;
    if (dx < 0) dx = -dx;
    if (dy < 0) dy = -dy;
    if (dz < 0) dz = -dz;
    if (dx > lim || dy > lim || dz > lim) return 8'd255;
    s = dx * dx + dy * dy + dz * dz;
    if (s <= unit * unit) return 8'd0;
    lhs = 65025 * s;
    lo = 0;
    hi = 255;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      t = 255 + 31 * mid;
      if (lhs >= unit * unit * t * t) lo = mid;
      else hi = mid - 1;
    end
    return lo[7:0];
  endfunction

  function automatic placement_t place_sound(logic signed [PW-1:0] sx,
                                             logic signed [PW-1:0] sy,
                                             logic signed [PW-1:0] sz,
                                             logic [3:0] chan);
    placement_t p;
    longint dx, dy, dz, rel;
    dx = longint'(sx) - longint'(lis_x);
    dy = longint'(sy) - longint'(lis_y);
    dz = longint'(sz) - longint'(lis_z);
    rel = heading_q16(dx, dz) - heading_q16(longint'(face_x), longint'(face_z));
    while (rel < 0) rel = rel + 360 * DEG;
    while (rel >= 360 * DEG) rel = rel - 360 * DEG;
    rel = rel >>> 16;
    if (rel > pabau_pkg::MAX_DEG) rel = pabau_pkg::MAX_DEG;
    p.chan = chan;
    p.bearing = rel[8:0];
    p.level = level_of(dx, dy, dz);
    return p;
  endfunction

  initial begin
    logic fire;
    placement_t got, want;
    forever begin
      @(negedge clk);
      fire = out_ch.valid && out_ch.ready;
      got.chan = out_ch.out_channel;
      got.bearing = out_ch.bearing_degrees;
      got.level = out_ch.distance_level;
      @(posedge clk);
      if (fire && !rst) begin
        if (placement_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result ch %0d bearing %0d level %0d",
                     got.chan, got.bearing, got.level);
        end else begin
          want = placement_q.pop_front();
          if (got.chan !== want.chan || got.bearing !== want.bearing ||
              got.level !== want.level) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected ch %0d bearing %0d level %0d, got %0d %0d %0d",
                       want.chan, want.bearing, want.level,
                       got.chan, got.bearing, got.level);
          end
        end
      end
    end
  end

  task automatic send_sound(logic signed [4:0] ch, logic signed [PW-1:0] sx,
                            logic signed [PW-1:0] sy, logic signed [PW-1:0] sz);
    logic ok;
    while ($urandom_range(99) < send_idle) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.mix_channel <= ch;
    in_ch.sound_x <= sx;
    in_ch.sound_y <= sy;
    in_ch.sound_z <= sz;
    do begin
      @(negedge clk);
      ok = in_ch.ready;
      @(posedge clk);
    end while (!ok);
    if (ch >= 0) placement_q.push_back(place_sound(sx, sy, sz, ch[3:0]));
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (placement_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic signed [PW-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      pabau_pkg::REG_LISTENER_X: lis_x = val;
      pabau_pkg::REG_LISTENER_Y: lis_y = val;
      pabau_pkg::REG_LISTENER_Z: lis_z = val;
      pabau_pkg::REG_FACING_X: face_x = val;
      pabau_pkg::REG_FACING_Z: face_z = val;
      default: ;
    endcase
  endtask

  task automatic set_listener(int x, int y, int z, int fx, int fz);
    wait_drained();
    write_reg(pabau_pkg::REG_LISTENER_X, PW'(x));
    write_reg(pabau_pkg::REG_LISTENER_Y, PW'(y));
    write_reg(pabau_pkg::REG_LISTENER_Z, PW'(z));
    write_reg(pabau_pkg::REG_FACING_X, PW'(fx));
    write_reg(pabau_pkg::REG_FACING_Z, PW'(fz));
  endtask

  function automatic logic signed [PW-1:0] near(logic signed [PW-1:0] c);
    longint v;
    v = longint'(c) + $urandom_range(0, 24000) - 12000;
    return v[PW-1:0];
  endfunction

  task automatic random_sound(bit near_only);
    logic signed [4:0] ch;
    ch = ($urandom_range(9) == 0) ? 5'($urandom) : 5'($urandom_range(15));
    if (near_only || $urandom_range(3) != 0)
      send_sound(ch, near(lis_x), near(lis_y), near(lis_z));
    else
      send_sound(ch, PW'($urandom), PW'($urandom), PW'($urandom));
  endtask

  task automatic test_reset_directed();
    send_sound(5'sd0, 0, 0, 0);
    send_sound(5'sd15, 0, 0, 256);
    send_sound(5'sd1, 0, 0, 257);
    send_sound(5'sd2, 0, 0, 8192);
    send_sound(5'sd3, 0, 0, 8191);
    send_sound(5'sd4, 8193, 0, 0);
    send_sound(5'sd5, 0, 0, -8193);
    send_sound(5'sd6, -1, 0, 5000);
    send_sound(5'sd7, 1, 0, 5000);
    send_sound(5'sd8, -300, 0, 0);
    send_sound(5'sd9, 0, 300, 0);
    send_sound(-5'sd1, 100, 100, 100);
    send_sound(-5'sd16, 0, 0, 0);
    send_sound(5'sd10, 24'sh7fffff, 24'sh7fffff, 24'sh7fffff);
    send_sound(5'sd11, -24'sh800000, -24'sh800000, -24'sh800000);
    send_sound(5'sd12, 3000, -2000, -4000);
    send_sound(5'sd13, -5000, 1000, 4500);
  endtask

  task automatic test_config_extremes();
    set_listener(24'sh7fffff, -24'sh800000, 24'sh7fffff, -24'sh800000, 24'sh7fffff);
    send_sound(5'sd0, -24'sh800000, 24'sh7fffff, -24'sh800000);
    send_sound(5'sd1, 24'sh7fffff, -24'sh800000, 24'sh7fffff);
    send_sound(5'sd2, 24'sh7ffff0, -24'sh7ffff0, 24'sh7ffff0);
    set_listener(100, -50, 25, 0, 0);
    send_sound(5'sd3, 100, -50, 25);
    send_sound(5'sd4, 600, -50, 900);
    wait_drained();
    write_reg(REG_SPARE, 24'sh123456);
    write_reg(REG_GAP, 24'sh654321);
    set_listener(0, 0, 0, 256, -256);
    send_sound(5'sd5, 1000, 0, 0);
    send_sound(5'sd6, 0, 0, 1000);
  endtask

  task automatic test_random_phases();
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: set_listener(0, 0, 0, 0, 256);
        1: set_listener(-4000, 1200, 7000, -256, 0);
        2: set_listener(PW'($urandom), PW'($urandom), PW'($urandom), -300, -700);
        default: set_listener($urandom_range(20000) - 10000, $urandom_range(2000) - 1000,
                              $urandom_range(20000) - 10000,
                              $urandom_range(2000) - 1000, $urandom_range(2000) - 1000);
      endcase
      case (ph)
        0: begin send_idle = 0; recv_stall = 0; end
        1: begin send_idle = 66; recv_stall = 0; end
        2: begin send_idle = 0; recv_stall = 66; end
        3: begin send_idle = 25; recv_stall = 25; end
        default: begin send_idle = 0; recv_stall = 0; end
      endcase
      repeat (90) random_sound(1'b0);
    end
  endtask

  task automatic test_backpressure();
    set_listener(0, 0, 0, 0, 256);
    send_idle = 0;
    recv_stall = 0;
    hold_off = 300;
    repeat (60) random_sound(1'b1);
    wait_drained();
    repeat (20) random_sound(1'b1);
  endtask

  initial begin
    lis_x = '0;
    lis_y = '0;
    lis_z = '0;
    face_x = '0;
    face_z = PW'(pabau_pkg::FACING_Z_RESET);
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_directed();
    test_config_extremes();
    test_random_phases();
    test_backpressure();
    wait_drained();
    if (mismatches == 0)
      $display("** positional_audio_bearing_and_attenuation_unit: PASSED **");
    else
      $display("** positional_audio_bearing_and_attenuation_unit: FAILED **");
    $finish;
  end

endmodule
